// File: rtl/hrr_pkg.sv
// Package for the histogram row rebinner: field widths, register indexes
// and the request/response types of the shared root and divide unit.
// No dependencies; every other file of the block imports it.
`default_nettype none

package hrr_pkg;

  // Configuration register widths and indexes.
  localparam int BINS_W    = 7;
  localparam int CFG_IDX_W = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_IN_BINS  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_BINS = 4'd1;

  // Item field widths.
  localparam int CONTENT_IN_W  = 32;
  localparam int ERROR_IN_W    = 16;
  localparam int CONTENT_OUT_W = 38;
  localparam int ERROR_OUT_W   = 22;
  localparam int IDX_W         = 6;
  localparam int IN_TDATA_W    = 48;
  localparam int OUT_TDATA_W   = 72;

  // Scaled edge positions reach in_bins * out_bins, at most 4096.
  localparam int POS_W = 13;

  // Accumulators and intermediate products.
  localparam int CSUM_W  = 40;
  localparam int ESUM_W  = 48;
  localparam int EO_W    = 23;

  // Shared unit: bit-pair root of an ESUM_W operand, restoring division.
  localparam int ROOT_W     = ESUM_W / 2;
  localparam int REM_W      = ROOT_W + 2;
  localparam int CNT_W      = 6;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_STEPS  = ESUM_W;

  typedef struct packed {
    logic              start;
    logic              is_sqrt;
    logic [ESUM_W-1:0] operand;
    logic [BINS_W-1:0] divisor;
  } hrr_req_t;

  typedef struct packed {
    logic              done;
    logic [ESUM_W-1:0] result;
  } hrr_resp_t;

endpackage

`default_nettype wire

// File: rtl/histogram_row_rebin_overlap.sv
// Histogram row rebinner: spreads each source bin over the output bins it
// overlaps and emits each output bin, content and quadrature error, once
// its upper edge is reached. An input item passes the multiply, square and
// add states, and for each output bin it completes the shared bit-serial
// unit runs a 24-step square root and two 48-step divisions. The block
// takes no item while one is at work.
// Depends on hrr_pkg and hrr_iter_unit.
`default_nettype none

module histogram_row_rebin_overlap #(
  parameter int MAX_BINS = 64
) (
  input  wire                                  clk_i,
  input  wire                                  rst_ni,
  // Configuration writes.
  input  wire                                  cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  wire  [hrr_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  wire  [hrr_pkg::BINS_W-1:0]           cfg_data_i,
  // Source bins.
  input  wire                                  s_axis_tvalid,
  output logic                                 s_axis_tready,
  // tdata: content_in[31:0], error_in[47:32].
  input  wire  [hrr_pkg::IN_TDATA_W-1:0]       s_axis_tdata,
  // Rebinned bins.
  output logic                                 m_axis_tvalid,
  input  wire                                  m_axis_tready,
  // tdata: content_out[37:0], error_out[59:38], out_index[65:60], zeros above.
  output logic [hrr_pkg::OUT_TDATA_W-1:0]      m_axis_tdata,
  // tlast: last_of_run.
  output logic                                 m_axis_tlast,
  // tuser: last_in_row.
  output logic                                 m_axis_tuser
);
  import hrr_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_MUL1 = 8'b0000_0010,
    S_MUL2 = 8'b0000_0100,
    S_ADD  = 8'b0000_1000,
    S_ROOT = 8'b0001_0000,
    S_DIVE = 8'b0010_0000,
    S_DIVC = 8'b0100_0000,
    S_OUT  = 8'b1000_0000
  } hrr_state_e;

  localparam logic [BINS_W-1:0] MaxBins = BINS_W'(MAX_BINS);

  function automatic logic [BINS_W-1:0] clamp_bins(input logic [BINS_W-1:0] v);
    logic [BINS_W-1:0] b;
    b = v;
    if (b == '0) b = BINS_W'(1);
    if (b > MaxBins) b = MaxBins;
    return b;
  endfunction

  hrr_state_e state_q, state_d;

  logic [BINS_W-1:0]              in_bins_q, in_bins_d;
  logic [BINS_W-1:0]              out_bins_q, out_bins_d;
  logic [BINS_W-1:0]              in_pos_q, in_pos_d;
  logic [BINS_W-1:0]              out_pos_q, out_pos_d;
  logic [POS_W-1:0]               lo_in_q, lo_in_d;
  logic [POS_W-1:0]               lo_out_q, lo_out_d;
  logic signed [CSUM_W-1:0]       csum_q, csum_d;
  logic [ESUM_W-1:0]              esum_q, esum_d;

  logic signed [CONTENT_IN_W-1:0] content_q, content_d;
  logic [ERROR_IN_W-1:0]          err_q, err_d;
  logic signed [CSUM_W-1:0]       cprod_q, cprod_d;
  logic [EO_W-1:0]                eo_q, eo_d;
  logic [ESUM_W-1:0]              sq_q, sq_d;
  logic [ERROR_OUT_W-1:0]         err_res_q, err_res_d;
  logic [CONTENT_OUT_W-1:0]       cout_q, cout_d;

  logic                           m_valid_q, m_valid_d;
  logic [CONTENT_OUT_W-1:0]       m_content_q;
  logic [ERROR_OUT_W-1:0]         m_error_q;
  logic [IDX_W-1:0]               m_index_q;
  logic                           m_last_q;
  logic                           m_user_q;

  hrr_req_t  req;
  hrr_resp_t resp;

  logic [POS_W-1:0]    hi_in, hi_out, lo, hi;
  logic [BINS_W-1:0]   ov;
  logic                last_bin, run_end, load, finish, restart;
  logic [CSUM_W-1:0]   mag;
  logic [ESUM_W-1:0]   half;

  hrr_iter_unit u_iter (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .resp_o (resp)
  );

  // Overlap of the current source bin with the current output bin.
  always_comb begin
    hi_in    = lo_in_q + POS_W'(out_bins_q);
    hi_out   = lo_out_q + POS_W'(in_bins_q);
    lo       = (lo_in_q > lo_out_q) ? lo_in_q : lo_out_q;
    hi       = (hi_in < hi_out) ? hi_in : hi_out;
    ov       = (hi > lo) ? BINS_W'(hi - lo) : '0;
    last_bin = (out_pos_q + BINS_W'(1)) == out_bins_q;
    run_end  = last_bin ||
               (({1'b0, hi_out} + (POS_W+1)'(in_bins_q)) > {1'b0, hi_in});
    mag      = csum_q[CSUM_W-1] ? CSUM_W'(-csum_q) : CSUM_W'(csum_q);
    half     = {{(ESUM_W-BINS_W+1){1'b0}}, out_bins_q[BINS_W-1:1]};
  end

  // Sequencer: accumulate, then root and divide for each finished bin.
  always_comb begin
    state_d    = state_q;
    in_bins_d  = in_bins_q;
    out_bins_d = out_bins_q;
    in_pos_d   = in_pos_q;
    out_pos_d  = out_pos_q;
    lo_in_d    = lo_in_q;
    lo_out_d   = lo_out_q;
    csum_d     = csum_q;
    esum_d     = esum_q;
    content_d  = content_q;
    err_d      = err_q;
    cprod_d    = cprod_q;
    eo_d       = eo_q;
    sq_d       = sq_q;
    err_res_d  = err_res_q;
    cout_d     = cout_q;
    req        = '0;
    load       = 1'b0;
    finish     = 1'b0;
    restart    = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          content_d = s_axis_tdata[CONTENT_IN_W-1:0];
          err_d     = s_axis_tdata[CONTENT_IN_W +: ERROR_IN_W];
          restart   = (in_pos_q >= in_bins_q) || (out_pos_q >= out_bins_q);
          state_d   = S_MUL1;
        end
      end
      S_MUL1: begin
        cprod_d = $signed({{(CSUM_W-CONTENT_IN_W){content_q[CONTENT_IN_W-1]}}, content_q})
                * $signed({{(CSUM_W-BINS_W){1'b0}}, ov});
        eo_d    = {{(EO_W-ERROR_IN_W){1'b0}}, err_q} * {{(EO_W-BINS_W){1'b0}}, ov};
        state_d = S_MUL2;
      end
      S_MUL2: begin
        sq_d    = {{(ESUM_W-EO_W){1'b0}}, eo_q} * {{(ESUM_W-EO_W){1'b0}}, eo_q};
        state_d = S_ADD;
      end
      S_ADD: begin
        csum_d = csum_q + cprod_q;
        esum_d = esum_q + sq_q;
        if (hi_out > hi_in) begin
          finish  = 1'b1;
          state_d = S_IDLE;
        end else begin
          req.start   = 1'b1;
          req.is_sqrt = 1'b1;
          req.operand = esum_d;
          req.divisor = out_bins_q;
          state_d     = S_ROOT;
        end
      end
      S_ROOT: begin
        if (resp.done) begin
          req.start   = 1'b1;
          req.operand = {{(ESUM_W-ROOT_W){1'b0}}, resp.result[ROOT_W-1:0]} + half;
          req.divisor = out_bins_q;
          state_d     = S_DIVE;
        end
      end
      S_DIVE: begin
        if (resp.done) begin
          err_res_d   = resp.result[ERROR_OUT_W-1:0];
          req.start   = 1'b1;
          req.operand = {{(ESUM_W-CSUM_W){1'b0}}, mag} + half;
          req.divisor = out_bins_q;
          state_d     = S_DIVC;
        end
      end
      S_DIVC: begin
        if (resp.done) begin
          cout_d  = csum_q[CSUM_W-1] ? (~resp.result[CONTENT_OUT_W-1:0] + CONTENT_OUT_W'(1))
                                     : resp.result[CONTENT_OUT_W-1:0];
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (!m_valid_q || m_axis_tready) begin
          load      = 1'b1;
          csum_d    = '0;
          esum_d    = '0;
          out_pos_d = out_pos_q + BINS_W'(1);
          lo_out_d  = lo_out_q + POS_W'(in_bins_q);
          if (last_bin) begin
            finish  = 1'b1;
            state_d = S_IDLE;
          end else begin
            state_d = S_MUL1;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // End of the source item: step the source edge or close the row.
    if (finish) begin
      if ((in_pos_q + BINS_W'(1)) >= in_bins_q) begin
        restart = 1'b1;
      end else begin
        in_pos_d = in_pos_q + BINS_W'(1);
        lo_in_d  = hi_in;
      end
    end

    // Writes to a bin-count register set the count and restart the row.
    if (cfg_valid_i) begin
      if (cfg_index_i == CFG_IN_BINS) begin
        in_bins_d = clamp_bins(cfg_data_i);
        restart   = 1'b1;
      end else if (cfg_index_i == CFG_OUT_BINS) begin
        out_bins_d = clamp_bins(cfg_data_i);
        restart    = 1'b1;
      end
    end

    if (restart) begin
      in_pos_d  = '0;
      out_pos_d = '0;
      lo_in_d   = '0;
      lo_out_d  = '0;
      csum_d    = '0;
      esum_d    = '0;
    end
  end

  // Output register: holds one result while the next one is worked out.
  always_comb begin
    m_valid_d = m_valid_q;
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      in_bins_q  <= MaxBins;
      out_bins_q <= MaxBins;
      in_pos_q   <= '0;
      out_pos_q  <= '0;
      lo_in_q    <= '0;
      lo_out_q   <= '0;
      csum_q     <= '0;
      esum_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      in_bins_q  <= in_bins_d;
      out_bins_q <= out_bins_d;
      in_pos_q   <= in_pos_d;
      out_pos_q  <= out_pos_d;
      lo_in_q    <= lo_in_d;
      lo_out_q   <= lo_out_d;
      csum_q     <= csum_d;
      esum_q     <= esum_d;
      m_valid_q  <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    content_q <= content_d;
    err_q     <= err_d;
    cprod_q   <= cprod_d;
    eo_q      <= eo_d;
    sq_q      <= sq_d;
    err_res_q <= err_res_d;
    cout_q    <= cout_d;
    if (load) begin
      m_content_q <= cout_q;
      m_error_q   <= err_res_q;
      m_index_q   <= out_pos_q[IDX_W-1:0];
      m_last_q    <= run_end;
      m_user_q    <= last_bin;
    end
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{(OUT_TDATA_W-CONTENT_OUT_W-ERROR_OUT_W-IDX_W){1'b0}},
                          m_index_q, m_error_q, m_content_q};
  assign m_axis_tlast  = m_last_q;
  assign m_axis_tuser  = m_user_q;

`ifndef SYNTH
  a_pos_in_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_IDLE |-> in_pos_q < in_bins_q)
    else $error("source position beyond the row while idle");
  a_load_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> $past(state_q == S_OUT))
    else $error("result loaded outside the output state");
  a_done_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp.done |-> (state_q == S_ROOT || state_q == S_DIVE || state_q == S_DIVC))
    else $error("unit finished while no result was awaited");
`endif

endmodule

`default_nettype wire

// File: rtl/hrr_iter_unit.sv
// Shared bit-serial unit: integer square root (two bits per step) or
// restoring division by a 7-bit divisor (one bit per step).
// Depends on hrr_pkg for widths and the request/response structs.
`default_nettype none

module hrr_iter_unit (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  hrr_pkg::hrr_req_t  req_i,
  output hrr_pkg::hrr_resp_t resp_o
);
  import hrr_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic              sqrt_q, sqrt_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [ESUM_W-1:0] x_q, x_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [BINS_W-1:0] div_q, div_d;

  logic [REM_W-1:0]  cand;
  logic [REM_W-1:0]  trial;
  logic [REM_W:0]    diff;
  logic              ge;

  // One compare and subtract serves both operations.
  always_comb begin
    if (sqrt_q) begin
      cand  = {rem_q[REM_W-3:0], x_q[ESUM_W-1 -: 2]};
      trial = {root_q, 2'b01};
    end else begin
      cand  = {{(REM_W-BINS_W){1'b0}}, rem_q[BINS_W-2:0], x_q[ESUM_W-1]};
      trial = {{(REM_W-BINS_W){1'b0}}, div_q};
    end
    diff = {1'b0, cand} - {1'b0, trial};
    ge   = ~diff[REM_W];
  end

  // Step sequencing: load on start, then one step per cycle.
  always_comb begin
    busy_d = busy_q;
    sqrt_d = sqrt_q;
    cnt_d  = cnt_q;
    x_d    = x_q;
    rem_d  = rem_q;
    root_d = root_q;
    div_d  = div_q;
    done_d = busy_q && (cnt_q == '0);
    if (req_i.start) begin
      busy_d = 1'b1;
      sqrt_d = req_i.is_sqrt;
      cnt_d  = req_i.is_sqrt ? CNT_W'(SQRT_STEPS - 1) : CNT_W'(DIV_STEPS - 1);
      x_d    = req_i.operand;
      rem_d  = '0;
      root_d = '0;
      div_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? diff[REM_W-1:0] : cand;
      if (sqrt_q) begin
        x_d    = {x_q[ESUM_W-3:0], 2'b00};
        root_d = {root_q[ROOT_W-2:0], ge};
      end else begin
        x_d = {x_q[ESUM_W-2:0], ge};
      end
      if (cnt_q == '0) begin
        busy_d = 1'b0;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      sqrt_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      sqrt_q <= sqrt_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    div_q  <= div_d;
  end

  assign resp_o.done   = done_q;
  assign resp_o.result = sqrt_q ? {{(ESUM_W-ROOT_W){1'b0}}, root_q} : x_q;

`ifndef SYNTH
  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !busy_q) else $error("unit started while busy");
  a_done_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(busy_q) && !busy_q) else $error("done without a finished run");
  a_div_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !sqrt_q |-> rem_q < {{(REM_W-BINS_W){1'b0}}, div_q})
    else $error("division remainder not below divisor");
`endif

endmodule

`default_nettype wire

// File: sim/histogram_row_rebin_overlap_tb.sv
// Self-checking testbench for the histogram row rebinner: random and directed
// source bins, a built-in rebinning predictor and a field-by-field result check.
// Depends on hrr_pkg and the histogram_row_rebin_overlap RTL.
`timescale 1ns / 100ps

module histogram_row_rebin_overlap_tb;

  localparam int CLK_HALF       = 4;
  localparam int RESET_CYCLES   = 5;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int MAX_PRINTS     = 40;
  localparam int NUM_BINS_MAX   = 64;
  // An index that maps to no register.
  localparam logic [hrr_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 4'd9;

  // One source bin as it travels on the input tdata.
  typedef struct packed {
    logic [15:0] err;
    logic [31:0] content;
  } src_bin_t;

  // One expected rebinned bin.
  typedef struct {
    logic [37:0] content;
    logic [21:0] err;
    logic [5:0]  idx;
    logic        last_run;
    logic        last_row;
  } rebin_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready_o;
  logic [hrr_pkg::CFG_IDX_W-1:0]   cfg_index = '0;
  logic [hrr_pkg::BINS_W-1:0]      cfg_data = '0;
  logic                            src_valid = 1'b0;
  logic                            s_axis_tready;
  src_bin_t                        src_item = '0;
  logic                            m_axis_tvalid;
  logic                            dst_ready = 1'b0;
  logic [hrr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic                            m_axis_tlast;
  logic                            m_axis_tuser;

  histogram_row_rebin_overlap uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (src_valid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (src_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (dst_ready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Source bins waiting to be offered, and rebinned bins still owed by the block.
  src_bin_t source_backlog[$];
  rebin_t   rebinned_due[$];
  int       n_queued = 0;
  int       n_taken = 0;
  int       mismatch_count = 0;

  // Idling control for the driver and the monitor, and the watchdog count.
  bit idle_on = 1'b0;
  int src_gap = 0;
  int dst_gap = 0;
  int holds_asked = 0;
  int holds_done = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Predictor state: row geometry, positions and the running sums.
  int unsigned       rb_in_bins = NUM_BINS_MAX;
  int unsigned       rb_out_bins = NUM_BINS_MAX;
  int unsigned       rb_in_pos = 0;
  int unsigned       rb_out_pos = 0;
  longint            rb_csum = 0;
  longint unsigned   rb_esq = 0;

  initial begin
    forever #CLK_HALF clk_i = ~clk_i;
  end

  function automatic int unsigned clamp_bins(logic [6:0] raw);
    if (raw == 0) return 1;
    if (raw > NUM_BINS_MAX) return NUM_BINS_MAX;
    return 32'(raw);
  endfunction

  // Integer square root, rounded down, by the digit-by-digit method.
  function automatic longint unsigned floor_root(longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  task automatic restart_row();
    rb_in_pos = 0;
    rb_out_pos = 0;
    rb_csum = 0;
    rb_esq = 0;
  endtask

  // Register writes to a valid index clamp the value and restart the row.
  task automatic apply_reg(logic [hrr_pkg::CFG_IDX_W-1:0] idx, logic [6:0] val);
    if (idx == hrr_pkg::CFG_IN_BINS) begin
      rb_in_bins = clamp_bins(val);
      restart_row();
    end else if (idx == hrr_pkg::CFG_OUT_BINS) begin
      rb_out_bins = clamp_bins(val);
      restart_row();
    end
  endtask

  // Spread one source bin over the output bins it overlaps and queue every
  // output bin whose upper edge it reaches.
  task automatic rebin_source(src_bin_t sb);
    rebin_t          run[$];
    rebin_t          bin;
    int unsigned     ib, ob, lo_in, hi_in, lo_out, hi_out, lo, hi, ov;
    longint          content;
    longint unsigned eo, mag, q, root;
    bit              stop;
    ib = rb_in_bins;
    ob = rb_out_bins;
    content = longint'($signed(sb.content));
    stop = 1'b0;
    if (rb_in_pos >= ib || rb_out_pos >= ob) restart_row();
    lo_in = rb_in_pos * ob;
    hi_in = lo_in + ob;
    while (rb_out_pos < ob && !stop) begin
      lo_out = rb_out_pos * ib;
      hi_out = lo_out + ib;
      lo = (lo_in > lo_out) ? lo_in : lo_out;
      hi = (hi_in < hi_out) ? hi_in : hi_out;
      // Bins that only touch at an edge contribute nothing.
      if (hi > lo) begin
        ov = hi - lo;
        eo = 64'(sb.err) * 64'(ov);
        rb_csum = rb_csum + content * longint'(ov);
        rb_esq = rb_esq + eo * eo;
      end
      if (hi_out > hi_in) begin
        stop = 1'b1;
      end else begin
        // Content rounds half away from zero, the error half up.
        mag = (rb_csum < 0) ? 64'(-rb_csum) : 64'(rb_csum);
        q = (mag + ob / 2) / ob;
        bin.content = (rb_csum < 0) ? 38'(64'd0 - q) : 38'(q);
        root = floor_root(rb_esq);
        bin.err = 22'((root + ob / 2) / ob);
        bin.idx = 6'(rb_out_pos);
        bin.last_run = 1'b0;
        bin.last_row = (rb_out_pos + 1 == ob);
        run.push_back(bin);
        rb_csum = 0;
        rb_esq = 0;
        rb_out_pos++;
      end
    end
    if (run.size() > 0) run[run.size() - 1].last_run = 1'b1;
    foreach (run[i]) rebinned_due.push_back(run[i]);
    rb_in_pos++;
    if (rb_in_pos >= ib) restart_row();
  endtask

  task automatic note_mismatch(string msg);
    if (mismatch_count < MAX_PRINTS) $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Compare one accepted output item with the oldest expected bin.
  task automatic check_bin();
    rebin_t want;
    if (rebinned_due.size() == 0) begin
      note_mismatch($sformatf("unexpected bin, tdata %0h", m_axis_tdata));
    end else begin
      want = rebinned_due.pop_front();
      if (m_axis_tdata[37:0] !== want.content)
        note_mismatch($sformatf("bin %0d content: got %0h, expected %0h",
                                want.idx, m_axis_tdata[37:0], want.content));
      if (m_axis_tdata[59:38] !== want.err)
        note_mismatch($sformatf("bin %0d error: got %0h, expected %0h",
                                want.idx, m_axis_tdata[59:38], want.err));
      if (m_axis_tdata[65:60] !== want.idx)
        note_mismatch($sformatf("out_index: got %0d, expected %0d",
                                m_axis_tdata[65:60], want.idx));
      if (m_axis_tdata[71:66] !== 6'd0)
        note_mismatch($sformatf("bin %0d padding bits: got %0h", want.idx,
                                m_axis_tdata[71:66]));
      if (m_axis_tlast !== want.last_run)
        note_mismatch($sformatf("bin %0d last_of_run: got %0b, expected %0b",
                                want.idx, m_axis_tlast, want.last_run));
      if (m_axis_tuser !== want.last_row)
        note_mismatch($sformatf("bin %0d last_in_row: got %0b, expected %0b",
                                want.idx, m_axis_tuser, want.last_row));
    end
  endtask

  // Driver: offers queued source bins, with short random gaps when idling is on.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (src_valid && s_axis_tready) begin
        rebin_source(src_item);
        n_taken++;
      end
      if (!src_valid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap <= src_gap - 1;
          src_valid <= 1'b0;
        end else if (source_backlog.size() > 0) begin
          src_item <= source_backlog.pop_front();
          src_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 3) == 0) src_gap <= $urandom_range(1, 3);
        end else begin
          src_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks results and paces tready, including the long hold-off.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && dst_ready) check_bin();
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        dst_ready <= 1'b0;
      end else if (holds_done < holds_asked) begin
        holds_done <= holds_done + 1;
        hold_left <= HOLD_CYCLES;
        dst_ready <= 1'b0;
      end else if (dst_gap > 0) begin
        dst_gap <= dst_gap - 1;
        dst_ready <= 1'b0;
      end else begin
        dst_ready <= 1'b1;
        if (idle_on && $urandom_range(0, 3) == 0) dst_gap <= $urandom_range(1, 3);
      end
    end
  end

  // Watchdog: ends the run if no item moves on any channel for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((cfg_valid && cfg_ready_o) || (src_valid && s_axis_tready) ||
          (m_axis_tvalid && dst_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  function automatic logic [31:0] pick_content();
    case ($urandom_range(0, 7))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 64) - 32;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [15:0] pick_error();
    case ($urandom_range(0, 7))
      0: return 16'hffff;
      1: return 16'h0000;
      2: return 16'($urandom_range(0, 15));
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic send(logic [31:0] content, logic [15:0] err);
    source_backlog.push_back({err, content});
    n_queued++;
  endtask

  // Wait until every queued bin is taken and every result is in, then let the
  // block finish any item that completes no output bin.
  task automatic settle();
    while (n_taken != n_queued || rebinned_due.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [hrr_pkg::CFG_IDX_W-1:0] idx, logic [6:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid <= 1'b0;
    apply_reg(idx, val);
    @(posedge clk_i);
  endtask

  task automatic random_phase(logic [6:0] in_raw, logic [6:0] out_raw, int n);
    settle();
    write_reg(hrr_pkg::CFG_IN_BINS, in_raw);
    write_reg(hrr_pkg::CFG_OUT_BINS, out_raw);
    repeat (n) send(pick_content(), pick_error());
  endtask

  // Stimulus sequence.
  initial begin
    logic [6:0] in_raw;
    logic [6:0] out_raw;
    int         n_items;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_on = 1'b1;

    // Field extremes with the reset geometry, one output bin per source bin.
    send(32'h7fff_ffff, 16'hffff);
    send(32'h8000_0000, 16'h0000);
    send(32'h0000_0000, 16'hffff);
    send(32'hffff_ffff, 16'h0001);
    send(32'h5555_5555, 16'haaaa);
    send(32'haaaa_aaaa, 16'h5555);
    settle();

    // A zero register value acts as one; halving odd sums hits rounding ties.
    write_reg(hrr_pkg::CFG_IN_BINS, 7'd0);
    write_reg(hrr_pkg::CFG_OUT_BINS, 7'd2);
    send(32'd3, 16'd1);
    send(-32'sd3, 16'd3);
    send(-32'sd1, 16'd1);
    send(32'd1, 16'hffff);
    send(32'h8000_0000, 16'hffff);
    send(32'h7fff_ffff, 16'hfffe);
    settle();

    // Partial overlaps; a write to no register leaves the row alone, while
    // a real write mid-row restarts it.
    write_reg(hrr_pkg::CFG_IN_BINS, 7'd3);
    write_reg(hrr_pkg::CFG_OUT_BINS, 7'd2);
    send(32'd100, 16'd7);
    settle();
    write_reg(CFG_NO_REG, 7'h55);
    send(-32'sd50, 16'd9);
    send(32'd25, 16'd1000);
    settle();
    send(32'd11, 16'd2);
    send(32'd13, 16'd4);
    settle();
    write_reg(hrr_pkg::CFG_OUT_BINS, 7'd2);
    send(32'd17, 16'd5);
    send(-32'sd19, 16'd6);
    send(32'd23, 16'd8);

    // Random part: equal sizes without idling, then the size extremes.
    idle_on = 1'b0;
    random_phase(7'd64, 7'd64, 40);
    idle_on = 1'b1;
    random_phase(7'd1, 7'd64, 3);
    holds_asked = holds_asked + 1;
    random_phase(7'd64, 7'd1, 64);
    random_phase(7'd127, 7'd3, 40);

    // Random geometries, mostly small, now and then out of range.
    for (int p = 0; p < 14; p++) begin
      in_raw = 7'($urandom_range(1, 12));
      out_raw = 7'($urandom_range(1, 16));
      if ($urandom_range(0, 7) == 0) out_raw = 7'($urandom_range(65, 127));
      if ($urandom_range(0, 7) == 0) in_raw = 7'd0;
      n_items = clamp_bins(in_raw) * $urandom_range(1, 2) + $urandom_range(0, 2);
      random_phase(in_raw, out_raw, n_items);
    end

    // Closing stretch at full rate on both sides.
    idle_on = 1'b0;
    random_phase(7'd5, 7'd8, 20);
    settle();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
